@@ src/strided_slice_index_generator_unit_assert.svh @@
// Assertion macros used by the back part (ssig_back) of the strided slice index generator RTL.
// Uses clk and arst_n of the module that includes this header.
`ifndef STRIDED_SLICE_INDEX_GENERATOR_UNIT_ASSERT_SVH
`define STRIDED_SLICE_INDEX_GENERATOR_UNIT_ASSERT_SVH
`ifndef SYNTH
`define SSIG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SSIG_ASSERT_IMPL(lbl, ante, cons, msg) \
	`SSIG_ASSERT(lbl, (ante) |-> (cons), msg)
`else
`define SSIG_ASSERT(lbl, prop, msg)
`define SSIG_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

@@ src/ssig_pkg.sv @@
// Shared types and constants of the strided slice index generator.
// No dependencies; imported by every module of the block.
package ssig_pkg;

	localparam int MAX_LEN = 64;
	localparam int LEN_W = $clog2(MAX_LEN + 1);
	localparam int IDX_W = $clog2(MAX_LEN);
	localparam int POS_W = LEN_W + 1;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_ZERO  = 2'd2;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_START = 2'd0;
	localparam logic [1:0] REG_STOP_GIVEN = 2'd1;
	localparam logic [1:0] REG_STOP = 2'd2;
	localparam logic [1:0] REG_STEP = 2'd3;

	typedef struct packed {
		logic signed [15:0] slice_start;
		logic               stop_given;
		logic signed [15:0] slice_stop;
		logic signed [15:0] slice_step;
	} cfg_t;

	// One resolved request, handed from the front part to the back part.
	typedef struct packed {
		logic [IDX_W-1:0] start_idx;
		logic [IDX_W-1:0] step_lo;
		logic [LEN_W-1:0] count;
		logic [1:0]       status;
	} entry_t;

endpackage

@@ src/strided_slice_index_generator_unit.sv @@
// Strided slice index generator: Python slice indices over a collection.
// The front spends a cycle per quotient bit in its 7 step serial divider and takes no new
// request until it has handed the last one over; the back emits one index per cycle
// while the output is not stalled. Reset: arst_n clears control; registers return to
// start 0, stop unset, step 1.
module strided_slice_index_generator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [6:0]  collection_size,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  element_index,
	output logic [6:0]  slice_count,
	output logic        last_of_run,
	output logic [1:0]  status
);
	import ssig_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;
	logic       push;
	entry_t     push_entry;
	logic       q_full;
	logic       pop;
	logic       q_valid;
	entry_t     head;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slice_start <= '0;
			cfg_q.stop_given <= 1'b0;
			cfg_q.slice_stop <= '0;
			cfg_q.slice_step <= 16'sd1;
		end else if (wr_en) begin
			case (reg_idx)
				REG_START: cfg_q.slice_start <= pwdata[15:0];
				REG_STOP_GIVEN: cfg_q.stop_given <= pwdata[0];
				REG_STOP: cfg_q.slice_stop <= pwdata[15:0];
				REG_STEP: cfg_q.slice_step <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		case (reg_idx)
			REG_START: prdata = {16'b0, cfg_q.slice_start};
			REG_STOP_GIVEN: prdata = {31'b0, cfg_q.stop_given};
			REG_STOP: prdata = {16'b0, cfg_q.slice_stop};
			REG_STEP: prdata = {16'b0, cfg_q.slice_step};
			default: prdata = '0;
		endcase
	end

	ssig_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.collection_size (collection_size),
		.push            (push),
		.push_entry      (push_entry),
		.q_full          (q_full)
	);

	ssig_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.q_valid    (q_valid),
		.head       (head)
	);

	ssig_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.element_index (element_index),
		.slice_count   (slice_count),
		.last_of_run   (last_of_run),
		.status        (status)
	);

endmodule

@@ src/ssig_front.sv @@
// Front part: accepts a collection size, resolves start and stop and
// divides out the index count serially. Depends on ssig_pkg.
module ssig_front (
	input  logic             clk,
	input  logic             arst_n,
	input  ssig_pkg::cfg_t   cfg,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [6:0]       collection_size,
	output logic             push,
	output ssig_pkg::entry_t push_entry,
	input  logic             q_full
);
	import ssig_pkg::*;

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_DIV  = 2'd1;
	localparam logic [1:0] F_PUSH = 2'd2;
	localparam int CNT_W = $clog2(LEN_W + 1);

	// Python style resolution of one position against the length.
	function automatic logic signed [POS_W-1:0] resolve(logic signed [15:0] pos,
			logic [LEN_W-1:0] len, logic signed [POS_W-1:0] lo,
			logic signed [POS_W-1:0] hi);
		logic signed [17:0] p;
		logic signed [17:0] s;
		logic signed [POS_W-1:0] r;
		p = $signed({{2{pos[15]}}, pos});
		s = p + $signed({{(18-LEN_W){1'b0}}, len});
		if (pos < 0) begin
			r = (s < lo) ? lo : s[POS_W-1:0];
		end else begin
			r = (p > hi) ? hi : p[POS_W-1:0];
		end
		return r;
	endfunction

	logic [1:0]              state_q;
	logic [LEN_W-1:0]        num_q;
	logic [LEN_W-1:0]        quo_q;
	logic [15:0]             rem_q;
	logic [15:0]             div_q;
	logic [CNT_W-1:0]        bit_q;
	logic [IDX_W-1:0]        start_q;
	logic [IDX_W-1:0]        step_q;
	logic [1:0]              status_q;

	logic [LEN_W-1:0]        len;
	logic                    step_neg;
	logic signed [POS_W-1:0] lower;
	logic signed [POS_W-1:0] upper;
	logic signed [POS_W-1:0] start_r;
	logic signed [POS_W-1:0] stop_r;
	logic signed [POS_W:0]   span;
	logic [15:0]             step_mag;
	logic [16:0]             rem_sh;
	logic [16:0]             rem_sub;
	logic                    rem_ge;
	logic                    accept;

	// Saturate the length and resolve the bounds for the step sign.
	always_comb begin
		len = (collection_size > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : collection_size;
		step_neg = cfg.slice_step[15];
		lower = step_neg ? -POS_W'(1) : '0;
		upper = step_neg ? $signed({1'b0, len}) - POS_W'(1) : $signed({1'b0, len});
		start_r = resolve(cfg.slice_start, len, lower, upper);
		stop_r = cfg.stop_given ? resolve(cfg.slice_stop, len, lower, upper)
			: (step_neg ? lower : upper);
		if (step_neg) begin
			span = $signed({start_r[POS_W-1], start_r}) - $signed({stop_r[POS_W-1], stop_r});
		end else begin
			span = $signed({stop_r[POS_W-1], stop_r}) - $signed({start_r[POS_W-1], start_r});
		end
		step_mag = step_neg ? 16'(-cfg.slice_step) : cfg.slice_step;
	end

	// One restoring division step per cycle.
	always_comb begin
		rem_sh = {rem_q[15:0], num_q[LEN_W-1]};
		rem_ge = rem_sh >= {1'b0, div_q};
		rem_sub = rem_sh - {1'b0, div_q};
	end

	assign accept = in_valid && !in_stall;
	assign in_stall = state_q != F_IDLE;
	assign push = (state_q == F_PUSH) && !q_full;

	always_comb begin
		push_entry.start_idx = start_q;
		push_entry.step_lo = step_q;
		push_entry.count = (status_q == ST_OK) ? quo_q + LEN_W'(1) : '0;
		push_entry.status = status_q;
	end

	// Control sequence: accept, divide (skipped for a zero step or an empty span), hand over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						if (cfg.slice_step == 16'sd0 || span <= 0) begin
							state_q <= F_PUSH;
						end else begin
							state_q <= F_DIV;
						end
					end
				end
				F_DIV: begin
					if (bit_q == CNT_W'(LEN_W - 1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the divider and the resolved request.
	always_ff @(posedge clk) begin
		if (accept) begin
			start_q <= start_r[IDX_W-1:0];
			step_q <= cfg.slice_step[IDX_W-1:0];
			num_q <= LEN_W'(span - 1);
			quo_q <= '0;
			rem_q <= '0;
			div_q <= step_mag;
			bit_q <= '0;
			if (cfg.slice_step == 16'sd0) begin
				status_q <= ST_ZERO;
			end else if (span <= 0) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q <= ST_OK;
			end
		end else if (state_q == F_DIV) begin
			num_q <= {num_q[LEN_W-2:0], 1'b0};
			quo_q <= {quo_q[LEN_W-2:0], rem_ge};
			rem_q <= rem_ge ? rem_sub[15:0] : rem_sh[15:0];
			bit_q <= bit_q + CNT_W'(1);
		end
	end

endmodule

@@ src/ssig_queue.sv @@
// Two entry queue between the front and back parts.
// Depends on ssig_pkg for the entry type.
module ssig_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ssig_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output logic             q_valid,
	output ssig_pkg::entry_t head
);
	import ssig_pkg::*;

	entry_t     mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] fill_q;

	assign full = fill_q == 2'd2;
	assign q_valid = fill_q != 2'd0;
	assign head = mem_q[rd_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

endmodule

@@ src/ssig_back.sv @@
// Back part: walks one resolved request, one index per cycle while the output is not
// stalled, into an output register. Depends on ssig_pkg and the assertion header.
`include "strided_slice_index_generator_unit_assert.svh"
module ssig_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  ssig_pkg::entry_t head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [5:0]       element_index,
	output logic [6:0]       slice_count,
	output logic             last_of_run,
	output logic [1:0]       status
);
	import ssig_pkg::*;

	logic             active_q;
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] step_q;
	logic [LEN_W-1:0] remain_q;
	logic [LEN_W-1:0] count_q;
	logic [1:0]       stat_q;
	logic             ovalid_q;
	logic [IDX_W-1:0] oidx_q;
	logic [LEN_W-1:0] ocount_q;
	logic             olast_q;
	logic [1:0]       ostat_q;
	logic             adv;
	logic             is_last;

	assign pop = !active_q && q_valid;
	assign adv = active_q && (!ovalid_q || !out_stall);
	assign is_last = (stat_q != ST_OK) || (remain_q == LEN_W'(1));

	assign out_valid = ovalid_q;
	assign element_index = oidx_q;
	assign slice_count = ocount_q;
	assign last_of_run = olast_q;
	assign status = ostat_q;

	// Control: current request and output register occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
			end else if (adv && is_last) begin
				active_q <= 1'b0;
			end
			if (adv) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Index walk and result fields.
	always_ff @(posedge clk) begin
		if (pop) begin
			pos_q <= head.start_idx;
			step_q <= head.step_lo;
			remain_q <= head.count;
			count_q <= head.count;
			stat_q <= head.status;
		end else if (adv) begin
			pos_q <= pos_q + step_q;
			remain_q <= remain_q - LEN_W'(1);
		end
		if (adv) begin
			oidx_q <= (stat_q == ST_OK) ? pos_q : '0;
			ocount_q <= count_q;
			olast_q <= is_last;
			ostat_q <= stat_q;
		end
	end

	`SSIG_ASSERT_IMPL(a_special_is_last, ovalid_q && ostat_q != ST_OK, olast_q, "special result not last")
	`SSIG_ASSERT_IMPL(a_ok_has_count, ovalid_q && ostat_q == ST_OK, ocount_q != '0, "index result with zero count")
	`SSIG_ASSERT_IMPL(a_walk_not_spent, active_q && stat_q == ST_OK, remain_q != '0, "index walk past its count")

endmodule

@@ tb/slice_index_checker.sv @@
// Checker for the strided slice index generator: tracks register writes, predicts
// the index run of every accepted request and compares each accepted result.
// Depends on ssig_pkg for the status codes, register indexes and MAX_LEN.
module slice_index_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [6:0]  collection_size,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [5:0]  element_index,
	input  logic [6:0]  slice_count,
	input  logic        last_of_run,
	input  logic [1:0]  status,
	output int          error_count,
	output int          results_pending
);
	import ssig_pkg::*;

	typedef struct packed {
		logic [5:0] index;
		logic [6:0] count;
		logic       last;
		logic [1:0] code;
	} slice_result_t;

	slice_result_t expected_indices[$];

	// Shadow copy of the slice registers.
	int   cfg_start;
	logic cfg_stop_given;
	int   cfg_stop;
	int   cfg_step;

	task automatic report_error(input string msg);
		$display("[%0t] slice check: %s", $time, msg);
		error_count++;
	endtask

	function automatic slice_result_t make_result(input int index, input int count,
			input logic last, input logic [1:0] code);
		slice_result_t r;
		r.index = index[5:0];
		r.count = count[6:0];
		r.last = last;
		r.code = code;
		return r;
	endfunction

	// Append one expected result behind the ones already waiting.
	function automatic void enqueue_result(input slice_result_t r);
		expected_indices.insert(expected_indices.size(), r);
	endfunction

	// Negative positions count from the end; the result is clamped to [lower, upper].
	function automatic int clamp_position(input int pos, input int len,
			input int lower, input int upper);
		if (pos < 0) begin
			pos += len;
			if (pos < lower)
				pos = lower;
		end else if (pos > upper) begin
			pos = upper;
		end
		return pos;
	endfunction

	// Resolve the slice for one collection length and queue the index run it selects.
	task automatic predict_slice(input logic [6:0] size_raw);
		int len;
		int lower;
		int upper;
		int first;
		int stop_pos;
		int count;
		int pos;
		len = (size_raw > MAX_LEN) ? MAX_LEN : int'(size_raw);
		if (cfg_step == 0) begin
			enqueue_result(make_result(0, 0, 1'b1, ST_ZERO));
		end else begin
			lower = (cfg_step > 0) ? 0 : -1;
			upper = (cfg_step > 0) ? len : len - 1;
			first = clamp_position(cfg_start, len, lower, upper);
			if (cfg_stop_given)
				stop_pos = clamp_position(cfg_stop, len, lower, upper);
			else
				stop_pos = (cfg_step > 0) ? upper : lower;
			count = 0;
			if (cfg_step > 0 && first < stop_pos)
				count = (stop_pos - first - 1) / cfg_step + 1;
			else if (cfg_step < 0 && stop_pos < first)
				count = (first - stop_pos - 1) / (-cfg_step) + 1;
			if (count <= 0) begin
				enqueue_result(make_result(0, 0, 1'b1, ST_EMPTY));
			end else begin
				pos = first;
				for (int i = 0; i < count; i++) begin
					enqueue_result(make_result(pos, count, i == count - 1, ST_OK));
					pos += cfg_step;
				end
			end
		end
	endtask

	// Everything is sampled at the rising edge; the stimulus changes at the falling one.
	always @(posedge clk or negedge arst_n) begin
		slice_result_t want;
		if (!arst_n) begin
			cfg_start = 0;
			cfg_stop_given = 1'b0;
			cfg_stop = 0;
			cfg_step = 1;
			expected_indices.delete();
		end else begin
			// Register writes complete in the access phase.
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_START:      cfg_start = int'($signed(pwdata[15:0]));
					REG_STOP_GIVEN: cfg_stop_given = pwdata[0];
					REG_STOP:       cfg_stop = int'($signed(pwdata[15:0]));
					REG_STEP:       cfg_step = int'($signed(pwdata[15:0]));
					default:        ;
				endcase
			end

			// Each accepted request adds its index run to the queue.
			if (in_valid && !in_stall)
				predict_slice(collection_size);

			// Each accepted result must match the oldest queued one.
			if (out_valid && !out_stall) begin
				if (expected_indices.size() == 0) begin
					report_error($sformatf("unexpected result: index %0d count %0d last %0b status %0d",
						element_index, slice_count, last_of_run, status));
				end else begin
					want = expected_indices.pop_front();
					if (element_index !== want.index)
						report_error($sformatf("element_index %0d, expected %0d",
							element_index, want.index));
					if (slice_count !== want.count)
						report_error($sformatf("slice_count %0d, expected %0d",
							slice_count, want.count));
					if (last_of_run !== want.last)
						report_error($sformatf("last_of_run %0b, expected %0b",
							last_of_run, want.last));
					if (status !== want.code)
						report_error($sformatf("status %0d, expected %0d", status, want.code));
				end
			end
		end
		results_pending = expected_indices.size();
	end

endmodule

@@ tb/strided_slice_index_generator_unit_test.sv @@
// Top of the strided slice index generator testbench: clock, reset, register
// writes and collection length requests, with the checker beside the block.
// Depends on ssig_pkg, the block and slice_index_checker.
module strided_slice_index_generator_unit_test;
	import ssig_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_PHASES = 11;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic [6:0]  collection_size;
	logic        out_valid;
	logic        out_stall;
	logic [5:0]  element_index;
	logic [6:0]  slice_count;
	logic        last_of_run;
	logic [1:0]  status;

	int error_count;
	int results_pending;
	int idle_cycles;
	int burst_left;
	bit long_hold;

	strided_slice_index_generator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.collection_size(collection_size),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.element_index(element_index),
		.slice_count(slice_count),
		.last_of_run(last_of_run),
		.status(status)
	);

	slice_index_checker checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.collection_size(collection_size),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.element_index(element_index),
		.slice_count(slice_count),
		.last_of_run(last_of_run),
		.status(status),
		.error_count(error_count),
		.results_pending(results_pending)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// End the run when nothing has moved on any port for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// The result side stalls in short random bursts, and once for a long stretch.
	initial begin
		int free_len;
		out_stall <= 1'b0;
		forever begin
			free_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
			// A pending long hold cuts the free stretch short.
			repeat (free_len) begin
				@(negedge clk);
				if (long_hold)
					break;
			end
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_hold = 1'b0;
			end else if ($urandom_range(0, 3) != 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	// One register write: setup cycle, then access cycle until pready.
	task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_slice(input int start, input bit given, input int stop, input int step);
		write_reg(REG_START, start);
		write_reg(REG_STOP_GIVEN, {31'd0, given});
		write_reg(REG_STOP, stop);
		write_reg(REG_STEP, step);
	endtask

	// Offer one request and hold it until accepted; gaps fall between bursts.
	task automatic send_length(input logic [6:0] size);
		collection_size <= size;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	endtask

	// Stop offering and wait until every queued result has come out.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (results_pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic int pick_position();
		int v;
		case ($urandom_range(0, 7))
			0: v = -32768;
			1: v = 32767;
			2: begin
				v = $urandom_range(0, 65535);
				if (v > 32767)
					v -= 65536;
			end
			default: begin
				v = $urandom_range(0, 150);
				v -= 75;
			end
		endcase
		return v;
	endfunction

	function automatic int pick_step();
		int v;
		case ($urandom_range(0, 11))
			0: v = 0;
			1: v = -32768;
			2: v = 32767;
			3: begin
				v = $urandom_range(0, 65535);
				if (v > 32767)
					v -= 65536;
			end
			default: begin
				v = $urandom_range(1, 5);
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	// Mostly short collections, some full ones and some above MAX_LEN.
	function automatic logic [6:0] pick_length();
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: v = $urandom_range(0, 16);
			6, 7:             v = $urandom_range(17, MAX_LEN);
			8:                v = $urandom_range(MAX_LEN + 1, 127);
			default:          v = MAX_LEN;
		endcase
		return v[6:0];
	endfunction

	initial begin
		int items;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		collection_size = '0;
		burst_left = 1;
		long_hold = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Registers at reset: the whole collection, including empty and oversized ones.
		send_length(7'd0);
		send_length(7'd1);
		send_length(7'd64);
		send_length(7'd65);
		send_length(7'd127);
		send_length(7'd7);
		drain_results();

		// A zero step is an error whatever the length.
		apply_slice(0, 1'b0, 0, 0);
		send_length(7'd5);
		send_length(7'd0);
		drain_results();

		// Reverse over the whole collection with the default stop.
		apply_slice(-1, 1'b0, 0, -1);
		send_length(7'd10);
		send_length(7'd0);
		drain_results();

		// Extreme positions and the largest positive step.
		apply_slice(-32768, 1'b1, 32767, 32767);
		send_length(7'd64);
		send_length(7'd3);
		drain_results();

		// Extreme positions and the most negative step.
		apply_slice(32767, 1'b1, -32768, -32768);
		send_length(7'd64);
		send_length(7'd1);
		drain_results();

		// Start equal to stop gives an empty slice.
		apply_slice(2, 1'b1, 2, 1);
		send_length(7'd10);
		drain_results();

		// Both ends counted from the end of the collection.
		apply_slice(-3, 1'b1, -1, 2);
		send_length(7'd20);
		drain_results();

		// Negative step with the stop clamped below element zero.
		apply_slice(-1, 1'b1, -100, -3);
		send_length(7'd40);
		send_length(7'd0);
		drain_results();

		// Negative step with the start clamped to the last element.
		apply_slice(100, 1'b1, 5, -2);
		send_length(7'd30);
		drain_results();

		// Random slices, each phase under its own register setting.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			apply_slice(pick_position(), 1'($urandom_range(0, 1)), pick_position(), pick_step());
			// One phase runs into a long result stall so the block backs up.
			if (phase == 2)
				long_hold = 1'b1;
			items = $urandom_range(12, 20);
			repeat (items) send_length(pick_length());
			drain_results();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0 && results_pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
